// ===== sv/udprdc_pkg.sv =====
// ----------------------------------------------------------------------------
// udprdc_pkg
// Shared types and constants of the UDP receive checker and port demultiplexer.
// ----------------------------------------------------------------------------
package udprdc_pkg;

  localparam int SOCKET_SLOTS = 8;
  localparam int SLOT_W       = 3;
  localparam int IN_DATA_W    = 168;
  localparam int OUT_DATA_W   = 40;

  localparam logic MODE_SOCK_WRITE = 1'b0;
  localparam logic MODE_DGRAM_WORD = 1'b1;

  localparam logic [15:0] UDP_PROTO = 16'd17;
  localparam logic [15:0] CSUM_OK   = 16'hffff;
  localparam logic [15:0] HDR_BYTES = 16'd8;
  localparam logic [15:0] WC_MAX    = 16'hffff;

  // header word positions
  localparam logic [15:0] W_SRC_PORT = 16'd0;
  localparam logic [15:0] W_DST_PORT = 16'd1;
  localparam logic [15:0] W_LENGTH   = 16'd2;
  localparam logic [15:0] W_CSUM     = 16'd3;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_BAD_LENGTH = 3'd1,
    ST_ZERO_PORT  = 3'd2,
    ST_NO_SOCKET  = 3'd3,
    ST_CSUM_ERROR = 3'd4
  } status_t;

  // tdata layout of the input channel, last member in the lowest bits
  typedef struct packed {
    logic [3:0]        pad;
    logic [15:0]       datagram_word;
    logic [15:0]       frame_bytes;
    logic [31:0]       dst_ip;
    logic [31:0]       src_ip;
    logic [15:0]       remote_port;
    logic [31:0]       peer_ip;
    logic [15:0]       local_port;
    logic              slot_in_use;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        pad;
    logic [15:0]       payload_bytes;
    logic [15:0]       source_port;
    logic [SLOT_W-1:0] socket_index;
    status_t           status;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic              in_use;
    logic [15:0]       port;
    logic [31:0]       peer_addr;
    logic [15:0]       remote_port;
  } sock_wr_t;

  typedef struct packed {
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] src_addr;
  } sock_query_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] index;
  } sock_match_t;

endpackage

// ===== sv/udprdc_socket_table.sv =====
// ----------------------------------------------------------------------------
// udprdc_socket_table
// Socket table with per-entry registers and a parallel first-match lookup.
// ----------------------------------------------------------------------------
module udprdc_socket_table
  import udprdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sock_wr_t    wr,
  input  sock_query_t query,
  output sock_match_t match
);

  logic        sock_open_r      [SOCKET_SLOTS];
  logic [15:0] sock_port_r      [SOCKET_SLOTS];
  logic [15:0] sock_rport_r     [SOCKET_SLOTS];
  logic [31:0] sock_peer_addr_r [SOCKET_SLOTS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < SOCKET_SLOTS; i++) begin
      if (!rst_n) begin
        sock_open_r[i] <= 1'b0;
      end else if (wr.en && 32'(wr.slot) == i) begin
        sock_open_r[i] <= wr.in_use;
      end
    end
  end

  // entry contents only matter while the entry is open
  always_ff @(posedge clk) begin
    for (int i = 0; i < SOCKET_SLOTS; i++) begin
      if (wr.en && 32'(wr.slot) == i) begin
        sock_port_r[i]      <= wr.port;
        sock_rport_r[i]     <= wr.remote_port;
        sock_peer_addr_r[i] <= wr.peer_addr;
      end
    end
  end

  always_comb begin
    logic hit;
    match = '0;
    for (int i = SOCKET_SLOTS - 1; i >= 0; i--) begin
      hit = sock_open_r[i] && sock_port_r[i] == query.dst_port &&
            (sock_rport_r[i] == 16'd0 ||
             (sock_rport_r[i] == query.src_port &&
              sock_peer_addr_r[i] == query.src_addr));
      // lowest matching entry wins
      if (hit) begin
        match.found = 1'b1;
        match.index = SLOT_W'(i);
      end
    end
  end

endmodule

// ===== sv/udp_receive_demux_check.sv =====
// ----------------------------------------------------------------------------
// udp_receive_demux_check
// Checks received UDP datagrams word by word (length, port, socket match,
// checksum) and returns one status word per datagram; also takes socket writes.
// ----------------------------------------------------------------------------
// output: the last word of a datagram passes the input register, then its status
// word is written to the result register that drives out_tvalid
// throughput: one word per cycle; in_tready drops only while a result waits
// on out_tready and the input register is full
// reset: synchronous, active low; clears the pipeline, the socket open bits
// and the datagram state
module udp_receive_demux_check
  import udprdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // slot, slot_in_use, local_port, peer_ip, remote_port, src_ip, dst_ip,
  // frame_bytes, datagram_word
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status, socket_index, source_port, payload_bytes
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      s1_mode_r;
  logic      s1_last_r;
  logic      advance;

  logic [15:0] word_count_r, word_count_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] dst_port_r, dst_port_nxt;
  logic [15:0] src_port_r, src_port_nxt;
  logic        csum_present_r, csum_present_nxt;
  logic [15:0] run_sum_r, run_sum_nxt;
  logic [31:0] src_addr_r, src_addr_nxt;
  logic [31:0] dst_addr_r, dst_addr_nxt;
  logic [15:0] frame_r, frame_nxt;

  logic        out_valid_r;
  out_item_t   out_item_r, out_item_nxt;

  sock_wr_t    sock_wr;
  sock_query_t sock_query;
  sock_match_t sock_match;

  logic        dgram_go;
  logic        first;
  logic [15:0] w;
  logic [16:0] byte_pos;
  logic [15:0] add_a, add_b;
  logic [19:0] acc;
  logic [16:0] fold1;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign dgram_go  = s1_valid_r && advance && s1_mode_r == MODE_DGRAM_WORD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= in_item_t'(in_tdata);
      s1_mode_r <= in_tuser;
      s1_last_r <= in_tlast;
    end
  end

  assign sock_wr.en          = s1_valid_r && advance && s1_mode_r == MODE_SOCK_WRITE;
  assign sock_wr.slot        = s1_item_r.slot;
  assign sock_wr.in_use      = s1_item_r.slot_in_use;
  assign sock_wr.port        = s1_item_r.local_port;
  assign sock_wr.peer_addr   = s1_item_r.peer_ip;
  assign sock_wr.remote_port = s1_item_r.remote_port;

  // header fields are settled once the checksum word is reached
  assign sock_query.dst_port = dst_port_r;
  assign sock_query.src_port = src_port_r;
  assign sock_query.src_addr = src_addr_r;

  udprdc_socket_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (sock_wr),
    .query (sock_query),
    .match (sock_match)
  );

  assign w        = s1_item_r.datagram_word;
  assign first    = word_count_r == W_SRC_PORT;
  assign byte_pos = {word_count_r, 1'b0};

  always_comb begin
    add_a = 16'd0;
    add_b = 16'd0;
    if (word_count_r <= W_CSUM) begin
      add_a = w;
      // length word counts once more for the pseudo-header
      if (word_count_r == W_LENGTH) add_b = w;
    end else if (byte_pos < {1'b0, length_r}) begin
      add_a = (byte_pos + 17'd1 == {1'b0, length_r}) ? {w[15:8], 8'h00} : w;
    end
  end

  // end-around carry sum, folded twice
  always_comb begin
    if (first) begin
      acc = 20'(s1_item_r.src_ip[31:16]) + 20'(s1_item_r.src_ip[15:0]) +
            20'(s1_item_r.dst_ip[31:16]) + 20'(s1_item_r.dst_ip[15:0]) +
            20'(UDP_PROTO) + 20'(add_a);
    end else begin
      acc = 20'(run_sum_r) + 20'(add_a) + 20'(add_b);
    end
    fold1       = 17'(acc[15:0]) + 17'(acc[19:16]);
    run_sum_nxt = fold1[15:0] + 16'(fold1[16]);
  end

  always_comb begin
    src_addr_nxt     = first ? s1_item_r.src_ip      : src_addr_r;
    dst_addr_nxt     = first ? s1_item_r.dst_ip      : dst_addr_r;
    frame_nxt        = first ? s1_item_r.frame_bytes : frame_r;
    src_port_nxt     = first ? w : src_port_r;
    dst_port_nxt     = (word_count_r == W_DST_PORT) ? w : (first ? 16'd0 : dst_port_r);
    length_nxt       = (word_count_r == W_LENGTH)   ? w : (first ? 16'd0 : length_r);
    csum_present_nxt = (word_count_r == W_CSUM) ? (w != 16'd0) :
                       (first ? 1'b0 : csum_present_r);
    if (s1_last_r) begin
      word_count_nxt = 16'd0;
    end else if (word_count_r != WC_MAX) begin
      word_count_nxt = word_count_r + 16'd1;
    end else begin
      word_count_nxt = word_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r   <= 16'd0;
      length_r       <= 16'd0;
      dst_port_r     <= 16'd0;
      src_port_r     <= 16'd0;
      csum_present_r <= 1'b0;
      run_sum_r      <= 16'd0;
      src_addr_r     <= 32'd0;
      dst_addr_r     <= 32'd0;
      frame_r        <= 16'd0;
    end else if (dgram_go) begin
      word_count_r   <= word_count_nxt;
      length_r       <= length_nxt;
      dst_port_r     <= dst_port_nxt;
      src_port_r     <= src_port_nxt;
      csum_present_r <= csum_present_nxt;
      run_sum_r      <= run_sum_nxt;
      src_addr_r     <= src_addr_nxt;
      dst_addr_r     <= dst_addr_nxt;
      frame_r        <= frame_nxt;
    end
  end

  // before the checksum word any last word is a bad length, so the length,
  // frame size and destination port can be taken from the registers
  always_comb begin
    out_item_nxt             = '0;
    out_item_nxt.source_port = src_port_nxt;
    if (word_count_r < W_CSUM || length_r < HDR_BYTES || length_r > frame_r) begin
      out_item_nxt.status = ST_BAD_LENGTH;
    end else if (dst_port_r == 16'd0) begin
      out_item_nxt.status = ST_ZERO_PORT;
    end else if (!sock_match.found) begin
      out_item_nxt.status = ST_NO_SOCKET;
    end else if (csum_present_nxt && run_sum_nxt != CSUM_OK) begin
      out_item_nxt.status = ST_CSUM_ERROR;
    end else begin
      out_item_nxt.status        = ST_ACCEPTED;
      out_item_nxt.socket_index  = sock_match.index;
      out_item_nxt.payload_bytes = length_r - HDR_BYTES;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= dgram_go && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (dgram_go && s1_last_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_item_r);

endmodule

// ===== sv/udprdc_checker.sv =====
// ----------------------------------------------------------------------------
// udprdc_checker
// Port-level checks on the UDP receive checker, bound to the top level.
// ----------------------------------------------------------------------------
module udprdc_checker
  import udprdc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  in_tuser,
  input logic                  in_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a rejected datagram reports no socket and no payload
  a_reject_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_ACCEPTED |->
      out_tdata[5:3] == 3'd0 && out_tdata[37:22] == 16'd0)
    else $error("rejected status with nonzero index or payload");

  // input stalls only behind a result that is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind udp_receive_demux_check udprdc_checker u_udprdc_checker (.*);

// ===== tb/udp_receive_demux_check_tb.sv =====
// ----------------------------------------------------------------------------
// udp_receive_demux_check_tb
// Self-checking bench for the UDP receive checker. It fills the socket table,
// sends directed and random datagrams (good, truncated, padded, corrupted) and
// checks each status word against a predictor of the socket table, the running
// checksum and the header checks. Sender and receiver idle at random.
// ----------------------------------------------------------------------------
module udp_receive_demux_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import udprdc_pkg::*;

  typedef enum int {CS_NONE, CS_GOOD, CS_BAD} csum_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // slot, slot_in_use, local_port, peer_ip,
                                     // remote_port, src_ip, dst_ip, frame_bytes,
                                     // datagram_word
  logic                  in_tuser;   // mode
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // status, socket_index, source_port,
                                     // payload_bytes

  udp_receive_demux_check dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predictor state
  logic        sk_open      [SOCKET_SLOTS];
  logic [15:0] sk_port      [SOCKET_SLOTS];
  logic [15:0] sk_rport     [SOCKET_SLOTS];
  logic [31:0] sk_peer_addr [SOCKET_SLOTS];
  logic [15:0] dg_count;
  logic [15:0] dg_len;
  logic [15:0] dg_dport;
  logic [15:0] dg_sport;
  logic        dg_csum_on;
  logic [15:0] dg_sum;
  logic [31:0] dg_src;
  logic [15:0] dg_frame;

  out_item_t   pending_status [$];
  logic [15:0] dg_words [$];
  logic [15:0] port_pool [4];
  out_item_t   got_status;
  out_item_t   want_status;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent    = 0;
  int mismatches    = 0;
  bit table_noise   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk) out_tready = ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [15:0] ones_add(logic [15:0] s, logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, v};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic void predict_status(logic mode, in_item_t d, logic last);
    logic [15:0] w;
    logic [15:0] idx;
    int unsigned byte_pos;
    out_item_t   res;
    bit          found;
    w   = d.datagram_word;
    idx = dg_count;
    if (mode == MODE_SOCK_WRITE) begin
      sk_open[d.slot]      = d.slot_in_use;
      sk_port[d.slot]      = d.local_port;
      sk_peer_addr[d.slot] = d.peer_ip;
      sk_rport[d.slot]     = d.remote_port;
      return;
    end
    if (idx == 0) begin
      dg_src     = d.src_ip;
      dg_frame   = d.frame_bytes;
      dg_sum     = ones_add(16'd0, d.src_ip[31:16]);
      dg_sum     = ones_add(dg_sum, d.src_ip[15:0]);
      dg_sum     = ones_add(dg_sum, d.dst_ip[31:16]);
      dg_sum     = ones_add(dg_sum, d.dst_ip[15:0]);
      dg_sum     = ones_add(dg_sum, UDP_PROTO);
      dg_sport   = '0;
      dg_dport   = '0;
      dg_len     = '0;
      dg_csum_on = 1'b0;
    end
    if (idx < 4) begin
      case (idx)
        W_SRC_PORT: dg_sport = w;
        W_DST_PORT: dg_dport = w;
        W_LENGTH: begin
          dg_len = w;
          // length goes into the pseudo-header too
          dg_sum = ones_add(dg_sum, w);
        end
        default: dg_csum_on = (w != 16'd0);
      endcase
      dg_sum = ones_add(dg_sum, w);
    end else begin
      byte_pos = 2 * idx;
      if (byte_pos < dg_len) begin
        if (byte_pos + 1 == dg_len) w[7:0] = 8'h00;
        dg_sum = ones_add(dg_sum, w);
      end
    end
    if (dg_count != WC_MAX) dg_count++;
    if (!last) return;

    res = '0;
    res.source_port = dg_sport;
    found = 1'b0;
    if (idx < W_CSUM || dg_len < HDR_BYTES || dg_len > dg_frame) begin
      res.status = ST_BAD_LENGTH;
    end else if (dg_dport == 16'd0) begin
      res.status = ST_ZERO_PORT;
    end else begin
      for (int i = 0; i < SOCKET_SLOTS; i++) begin
        if (!found && sk_open[i] && sk_port[i] == dg_dport &&
            (sk_rport[i] == 16'd0 ||
             (sk_rport[i] == dg_sport && sk_peer_addr[i] == dg_src))) begin
          found = 1'b1;
          res.socket_index = SLOT_W'(i);
        end
      end
      if (!found) begin
        res.status = ST_NO_SOCKET;
      end else if (dg_csum_on && dg_sum != CSUM_OK) begin
        res.status       = ST_CSUM_ERROR;
        res.socket_index = '0;
      end else begin
        res.status        = ST_ACCEPTED;
        res.payload_bytes = dg_len - HDR_BYTES;
      end
    end
    pending_status.push_back(res);
    dg_count = '0;
  endfunction

  function automatic void report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) report($sformatf("%s expected %0h got %0h", name, want, got));
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_status = out_item_t'(out_tdata);
      if (pending_status.size() == 0) begin
        report($sformatf("status word %0h with none expected", out_tdata));
      end else begin
        want_status = pending_status.pop_front();
        check_field("status", 16'(want_status.status), 16'(got_status.status));
        check_field("socket_index", 16'(want_status.socket_index),
                    16'(got_status.socket_index));
        check_field("source_port", want_status.source_port, got_status.source_port);
        check_field("payload_bytes", want_status.payload_bytes,
                    got_status.payload_bytes);
      end
    end
  end

  function automatic in_item_t random_item();
    in_item_t d;
    d.pad           = '0;
    d.slot          = 3'($urandom);
    d.slot_in_use   = 1'($urandom);
    d.local_port    = 16'($urandom);
    d.peer_ip       = $urandom;
    d.remote_port   = 16'($urandom);
    d.src_ip        = $urandom;
    d.dst_ip        = $urandom;
    d.frame_bytes   = 16'($urandom);
    d.datagram_word = 16'($urandom);
    return d;
  endfunction

  function automatic logic [15:0] pick_port();
    if ($urandom_range(99) < 70) return port_pool[$urandom_range(3)];
    return 16'($urandom);
  endfunction

  // called and left at a falling edge; in_tvalid is low on return
  task automatic send_word(input logic mode, input in_item_t d, input logic last);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = d;
    in_tuser  = mode;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    predict_status(mode, d, last);
    words_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_socket(input logic [2:0] slot, input logic in_use,
                              input logic [15:0] port, input logic [31:0] peer_addr,
                              input logic [15:0] rport);
    in_item_t d;
    d             = random_item();
    d.slot        = slot;
    d.slot_in_use = in_use;
    d.local_port  = port;
    d.peer_ip     = peer_addr;
    d.remote_port = rport;
    send_word(MODE_SOCK_WRITE, d, 1'($urandom_range(1)));
  endtask

  task automatic random_socket_write();
    logic [15:0] rport;
    rport = $urandom_range(1) ? 16'd0 : 16'($urandom);
    write_socket(3'($urandom_range(SOCKET_SLOTS - 1)), $urandom_range(99) < 80,
                 pick_port(), $urandom, rport);
  endtask

  // builds the datagram with its checksum, then trims or extends it to n_words
  task automatic send_udp(input logic [31:0] sip, input logic [31:0] dip,
                          input logic [15:0] fbytes, input logic [15:0] sport,
                          input logic [15:0] dport, input logic [15:0] len,
                          input csum_kind_t ck, input int n_words);
    logic [15:0] acc;
    logic [15:0] csum;
    logic [15:0] w;
    in_item_t    d;
    int          full_words;
    full_words = (int'(len) + 1) / 2;
    if (full_words < 4) full_words = 4;
    if (n_words == 0) n_words = full_words;
    dg_words.delete();
    for (int i = 0; i < full_words; i++) dg_words.push_back(16'($urandom));
    dg_words[0] = sport;
    dg_words[1] = dport;
    dg_words[2] = len;
    dg_words[3] = 16'd0;
    acc = ones_add(16'd0, sip[31:16]);
    acc = ones_add(acc, sip[15:0]);
    acc = ones_add(acc, dip[31:16]);
    acc = ones_add(acc, dip[15:0]);
    acc = ones_add(acc, UDP_PROTO);
    acc = ones_add(acc, len);
    for (int i = 0; i < full_words; i++) begin
      w = dg_words[i];
      if (i >= 4 && 2 * i + 1 == int'(len)) w[7:0] = 8'h00;
      if (i < 4 || 2 * i < int'(len)) acc = ones_add(acc, w);
    end
    csum = ~acc;
    if (csum == 16'd0) csum = 16'hffff;
    case (ck)
      CS_NONE: csum = 16'd0;
      CS_BAD:  csum = csum ^ 16'($urandom_range(1, 16'hffff));
      default: ;
    endcase
    dg_words[3] = csum;
    while (dg_words.size() > n_words) void'(dg_words.pop_back());
    while (dg_words.size() < n_words) dg_words.push_back(16'($urandom));

    foreach (dg_words[i]) begin
      d = random_item();
      if (i == 0) begin
        d.src_ip      = sip;
        d.dst_ip      = dip;
        d.frame_bytes = fbytes;
      end
      d.datagram_word = dg_words[i];
      send_word(MODE_DGRAM_WORD, d, i == dg_words.size() - 1);
      // table change inside a datagram
      if (table_noise && i != dg_words.size() - 1 && $urandom_range(99) < 3)
        random_socket_write();
    end
  endtask

  task automatic random_datagram();
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] len;
    logic [15:0] fbytes;
    int          pick;
    int          r;
    int          full_words;
    int          n;
    csum_kind_t  ck;
    sip   = $urandom;
    dip   = $urandom;
    sport = 16'($urandom);
    dport = 16'($urandom);
    pick  = $urandom_range(SOCKET_SLOTS - 1);
    if ($urandom_range(99) < 75) begin
      dport = sk_port[pick];
      if (sk_rport[pick] != 16'd0 && $urandom_range(99) < 80) begin
        sip   = sk_peer_addr[pick];
        sport = sk_rport[pick];
      end
    end else if ($urandom_range(99) < 15) begin
      dport = 16'd0;
    end
    r = $urandom_range(99);
    if (r < 6)       len = 16'($urandom_range(7));
    else if (r < 10) len = 16'($urandom);
    else if (r < 15) len = 16'($urandom_range(41, 200));
    else             len = 16'($urandom_range(8, 40));
    r = $urandom_range(99);
    if (r < 8)       fbytes = 16'($urandom);
    else if (r < 14) fbytes = len - 16'd1;
    else             fbytes = len + 16'($urandom_range(8));
    full_words = (int'(len) + 1) / 2;
    if (full_words < 4) full_words = 4;
    r = $urandom_range(99);
    if (full_words > 120) n = $urandom_range(4, 30);
    else if (r < 8)       n = $urandom_range(1, full_words - 1);
    else if (r < 18)      n = full_words + $urandom_range(1, 3);
    else                  n = full_words;
    r = $urandom_range(99);
    if (r < 15)      ck = CS_NONE;
    else if (r < 25) ck = CS_BAD;
    else             ck = CS_GOOD;
    send_udp(sip, dip, fbytes, sport, dport, len, ck, n);
  endtask

  // hold the sender until every status word is back
  task automatic wait_for_results();
    while (pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_socket_writes();
    write_socket(3'd0, 1'b1, 16'h1234, 32'h0, 16'h0);
    write_socket(3'd1, 1'b1, 16'h1234, 32'h0a000001, 16'h0400);
    write_socket(3'd2, 1'b1, 16'hffff, 32'hffffffff, 16'hffff);
    write_socket(3'd7, 1'b0, 16'h5555, 32'h0, 16'h0);
  endtask

  task automatic test_header_checks();
    // odd length with a garbage pad byte, first of two matching slots wins
    send_udp(32'h0a000001, 32'h0a000002, 16'd9, 16'h0400, 16'h1234, 16'd9, CS_GOOD, 0);
    // connected peer match, bare header, no checksum
    send_udp(32'hffffffff, 32'h0, 16'hffff, 16'hffff, 16'hffff, 16'd8, CS_NONE, 0);
    // peer address differs
    send_udp(32'hfffffffe, 32'h0, 16'hffff, 16'hffff, 16'hffff, 16'd8, CS_NONE, 0);
    // ends before the header is complete
    send_udp(32'h0, 32'h0, 16'd0, 16'h0000, 16'h1234, 16'd8, CS_NONE, 2);
    send_udp($urandom, $urandom, 16'd8, 16'h0001, 16'h0000, 16'd8, CS_GOOD, 0);
    // closed slot
    send_udp($urandom, $urandom, 16'd8, 16'h0001, 16'h5555, 16'd8, CS_NONE, 0);
    send_udp($urandom, $urandom, 16'd8, 16'h0002, 16'h1234, 16'd8, CS_BAD, 0);
    // stream stops short of the length
    send_udp($urandom, $urandom, 16'd16, 16'h0003, 16'h1234, 16'd16, CS_GOOD, 5);
    // words past the length are ignored
    send_udp($urandom, $urandom, 16'd12, 16'h0004, 16'h1234, 16'd10, CS_GOOD, 8);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_items);
    int stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    table_noise   = 1'b1;
    stop_at       = words_sent + n_items;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 10) random_socket_write();
      else random_datagram();
    end
    table_noise = 1'b0;
    wait_for_results();
  endtask

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    for (int i = 0; i < SOCKET_SLOTS; i++) begin
      sk_open[i]      = 1'b0;
      sk_port[i]      = '0;
      sk_rport[i]     = '0;
      sk_peer_addr[i] = '0;
    end
    dg_count   = '0;
    dg_len     = '0;
    dg_dport   = '0;
    dg_sport   = '0;
    dg_csum_on = 1'b0;
    dg_sum     = '0;
    dg_src     = '0;
    dg_frame   = '0;
    port_pool[0] = 16'h1234;
    port_pool[1] = 16'hffff;
    port_pool[2] = 16'($urandom_range(1, 16'hffff));
    port_pool[3] = 16'($urandom_range(1, 16'hffff));
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 8;
    recv_idle_pct = 79;
    test_socket_writes();
    test_header_checks();
    for (int i = 0; i < SOCKET_SLOTS; i++) random_socket_write();
    test_random_traffic(8, 79, 390);
    test_random_traffic(79, 8, 390);
    test_random_traffic(0, 0, 390);

    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/udprdc_pkg.sv
sv/udprdc_socket_table.sv
sv/udp_receive_demux_check.sv
sv/udprdc_checker.sv
tb/udp_receive_demux_check_tb.sv
